/* src/cbps_pkg.sv */
// Shared types, constants and the Bernstein weight table for the Bezier path smoother.
// Used by every module in src; no dependencies.
package cbps_pkg;

  localparam int NUM_SAMPLES = 10;
  localparam int N1          = NUM_SAMPLES - 1;
  localparam int DEN         = N1 * N1 * N1;
  localparam int WW          = $clog2(DEN + 1);     // weight width, every weight <= DEN
  localparam int PW          = 33 + WW;             // signed weight * coordinate
  localparam int UW          = 33 + WW;             // biased dividend, always non-negative
  localparam int QB          = 32;                  // quotient bits
  localparam int JW          = $clog2(NUM_SAMPLES);
  localparam int QDEPTH      = 2;

  typedef logic [WW-1:0] wgt_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  typedef struct packed {
    pt_t  p0;
    pt_t  p1;
    pt_t  p2;
    pt_t  p3;
    logic last;
  } seg_t;

  typedef struct packed {
    logic vld;
    logic seg_end;
    logic path_end;
  } tag_t;

  // weights a^3, 3ba^2, 3b^2a, b^3 with b = j, a = N1 - j; entry (j*4+k)
  function automatic logic [NUM_SAMPLES*4*WW-1:0] build_wtab();
    logic [NUM_SAMPLES*4*WW-1:0] t;
    int a;
    int b;
    t = '0;
    for (int j = 0; j < NUM_SAMPLES; j++) begin
      b = j;
      a = N1 - j;
      t[(j*4+0)*WW +: WW] = WW'(a * a * a);
      t[(j*4+1)*WW +: WW] = WW'(3 * b * a * a);
      t[(j*4+2)*WW +: WW] = WW'(3 * b * b * a);
      t[(j*4+3)*WW +: WW] = WW'(b * b * b);
    end
    return t;
  endfunction

  localparam logic [NUM_SAMPLES*4*WW-1:0] WTAB = build_wtab();

  // floor((a+b)/2) on the 33-bit sum
  function automatic pt_t midpoint(pt_t a, pt_t b);
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    pt_t m;
    sx  = {a.x[31], a.x} + {b.x[31], b.x};
    sy  = {a.y[31], a.y} + {b.y[31], b.y};
    m.x = sx[32:1];
    m.y = sy[32:1];
    return m;
  endfunction

endpackage

/* src/cbps_front.sv */
// Front end: accepts waypoints, tracks pairing state and builds control points.
// Depends on cbps_pkg; pushes finished segments into cbps_queue.
module cbps_front import cbps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pt_t  in_pt,
  input  logic in_fin,
  input  logic q_full,
  output logic push,
  output seg_t push_seg
);

  pt_t  prior_r, prior_nxt;
  pt_t  first_r, first_nxt;
  pt_t  second_r, second_nxt;
  logic odd_r, odd_nxt;
  logic pend_r, pend_nxt;
  logic firstp_r, firstp_nxt;
  logic acc;
  pt_t  start_pt;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign start_pt = firstp_r ? first_r : midpoint(prior_r, first_r);

  always_comb begin
    prior_nxt   = prior_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    odd_nxt     = odd_r;
    pend_nxt    = pend_r;
    firstp_nxt  = firstp_r;
    push        = 1'b0;
    push_seg.p0 = start_pt;
    push_seg.p1 = first_r;
    push_seg.p2 = second_r;
    push_seg.p3 = in_fin ? second_r : midpoint(second_r, in_pt);
    push_seg.last = in_fin;
    if (acc) begin
      if (!odd_r) begin
        if (pend_r) begin
          push       = 1'b1;
          prior_nxt  = second_r;
          firstp_nxt = 1'b0;
          pend_nxt   = 1'b0;
        end
        if (in_fin) begin
          odd_nxt    = 1'b0;
          pend_nxt   = 1'b0;
          firstp_nxt = 1'b1;
        end else begin
          first_nxt = in_pt;
          odd_nxt   = 1'b1;
        end
      end else begin
        second_nxt = in_pt;
        odd_nxt    = 1'b0;
        if (in_fin) begin
          // closing pair: p3 = p2 = this point
          push          = 1'b1;
          push_seg.p2   = in_pt;
          push_seg.p3   = in_pt;
          push_seg.last = 1'b1;
          prior_nxt     = in_pt;
          pend_nxt      = 1'b0;
          firstp_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r  <= '0;
      first_r  <= '0;
      second_r <= '0;
      odd_r    <= 1'b0;
      pend_r   <= 1'b0;
      firstp_r <= 1'b1;
    end else begin
      prior_r  <= prior_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      odd_r    <= odd_nxt;
      pend_r   <= pend_nxt;
      firstp_r <= firstp_nxt;
    end
  end

endmodule

/* src/cbps_queue.sv */
// Short segment queue between front end and sample engine.
// Depends on cbps_pkg for seg_t and QDEPTH.
module cbps_queue import cbps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  seg_t push_seg,
  output logic full,
  input  logic pop,
  output logic empty,
  output seg_t head
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW  = $clog2(QDEPTH + 1);

  seg_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CW'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("segment pushed into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

/* src/cbps_div.sv */
// Divider by the constant 2*DEN for the x and y lanes: exact reciprocal multiply, three stages.
// Depends on cbps_pkg; the last stage doubles as the output register.
module cbps_div import cbps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  tag_t          in_tag,
  input  logic [UW-1:0] u_x,
  input  logic [UW-1:0] u_y,
  output tag_t          out_tag,
  output logic [QB-1:0] q_x,
  output logic [QB-1:0] q_y
);

  // floor(u / 2D) = floor((u >> 1) / D). With M = ceil(2^KS / D) and KS = NW + WW the
  // error M*D - 2^KS stays below 2^WW, so (n * M) >> KS is exact for every NW-bit n.
  localparam int NW  = UW - 1;
  localparam int KS  = NW + WW;
  localparam int MW  = NW + 2;
  localparam logic [63:0] RECIP = ((64'd1 << KS) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam int NL  = NW / 2;
  localparam int NH  = NW - NL;
  localparam int ML  = MW / 2;
  localparam int MH  = MW - ML;
  localparam logic [ML-1:0] M_LO = RECIP[ML-1:0];
  localparam logic [MH-1:0] M_HI = RECIP[MW-1:ML];
  localparam int HHW = NH + MH;
  localparam int HLW = NH + ML;
  localparam int LHW = NL + MH;
  localparam int LLW = NL + ML;
  localparam int PWD = NW + MW;

  logic [NW-1:0]  n_in [2];
  logic [HHW-1:0] hh_r [2];
  logic [HLW-1:0] hl_r [2];
  logic [LHW-1:0] lh_r [2];
  logic [LLW-1:0] ll_r [2];
  logic [PWD-1:0] sa_r [2];
  logic [PWD-1:0] sb_r [2];
  logic [QB-1:0]  q_r  [2];
  tag_t           tag_r [3];

  assign n_in[0] = u_x[UW-1:1];
  assign n_in[1] = u_y[UW-1:1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        // partial products of the split dividend and reciprocal
        hh_r[l] <= HHW'(n_in[l][NW-1:NL]) * HHW'(M_HI);
        hl_r[l] <= HLW'(n_in[l][NW-1:NL]) * HLW'(M_LO);
        lh_r[l] <= LHW'(n_in[l][NL-1:0]) * LHW'(M_HI);
        ll_r[l] <= LLW'(n_in[l][NL-1:0]) * LLW'(M_LO);
        sa_r[l] <= (PWD'(hh_r[l]) << (NL + ML)) + (PWD'(hl_r[l]) << NL);
        sb_r[l] <= (PWD'(lh_r[l]) << ML) + PWD'(ll_r[l]);
        q_r[l]  <= QB'((sa_r[l] + sb_r[l]) >> KS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
      tag_r[1] <= '0;
      tag_r[2] <= '0;
    end else if (en) begin
      tag_r[0] <= in_tag;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
    end
  end

  assign out_tag = tag_r[2];
  assign q_x     = q_r[0];
  assign q_y     = q_r[1];

endmodule

/* src/cbps_back.sv */
// Sample engine: steps t over each queued segment, weighted sums, rounding divide.
// Depends on cbps_pkg and cbps_div.
module cbps_back import cbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  seg_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        out_seg_end,
  output logic        out_path_end
);

  // 2*S + DEN, offset by 2^32*DEN so the dividend never goes negative
  localparam logic [UW-1:0] BIAS = UW'(DEN) + (UW'(DEN) << 32);

  logic                 adv;
  logic                 issue;
  logic                 j_last;
  logic [JW-1:0]        j_r, j_nxt;
  pt_t                  pts [4];
  tag_t                 s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, div_tag;
  wgt_t                 s1_w_r [4];
  pt_t                  s1_p_r [4];
  logic signed [PW-1:0] s2_px_r [4];
  logic signed [PW-1:0] s2_py_r [4];
  logic signed [PW:0]   s3_ax_r, s3_bx_r, s3_ay_r, s3_by_r;
  logic [UW-1:0]        sum_x, sum_y;
  logic [UW-1:0]        s4_ux_r, s4_uy_r;
  logic [QB-1:0]        q_x, q_y;

  assign pts[0] = q_head.p0;
  assign pts[1] = q_head.p1;
  assign pts[2] = q_head.p2;
  assign pts[3] = q_head.p3;

  // whole pipe moves when the output beat is empty or taken
  assign adv    = !div_tag.vld || out_ready;
  assign issue  = adv && !q_empty;
  assign j_last = (j_r == JW'(N1));
  assign q_pop  = issue && j_last;

  always_comb begin
    j_nxt = j_r;
    if (issue) begin
      j_nxt = j_last ? '0 : j_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r      <= '0;
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
    end else begin
      j_r <= j_nxt;
      if (adv) begin
        s1_tag_r <= '{vld: issue, seg_end: j_last, path_end: issue && j_last && q_head.last};
        s2_tag_r <= s1_tag_r;
        s3_tag_r <= s2_tag_r;
        s4_tag_r <= s3_tag_r;
      end
    end
  end

  assign sum_x = UW'(s3_ax_r) + UW'(s3_bx_r);
  assign sum_y = UW'(s3_ay_r) + UW'(s3_by_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s1_w_r[k]  <= WTAB[(int'(j_r) * 4 + k) * WW +: WW];
        s1_p_r[k]  <= pts[k];
        s2_px_r[k] <= $signed({1'b0, s1_w_r[k]}) * $signed(s1_p_r[k].x);
        s2_py_r[k] <= $signed({1'b0, s1_w_r[k]}) * $signed(s1_p_r[k].y);
      end
      s3_ax_r <= (PW+1)'(s2_px_r[0]) + (PW+1)'(s2_px_r[1]);
      s3_bx_r <= (PW+1)'(s2_px_r[2]) + (PW+1)'(s2_px_r[3]);
      s3_ay_r <= (PW+1)'(s2_py_r[0]) + (PW+1)'(s2_py_r[1]);
      s3_by_r <= (PW+1)'(s2_py_r[2]) + (PW+1)'(s2_py_r[3]);
      s4_ux_r <= (sum_x << 1) + BIAS;
      s4_uy_r <= (sum_y << 1) + BIAS;
    end
  end

  cbps_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_tag  (s4_tag_r),
    .u_x     (s4_ux_r),
    .u_y     (s4_uy_r),
    .out_tag (div_tag),
    .q_x     (q_x),
    .q_y     (q_y)
  );

  // quotient carries a +2^31 offset: flip the sign bit
  assign out_valid    = div_tag.vld;
  assign out_x        = {~q_x[QB-1], q_x[QB-2:0]};
  assign out_y        = {~q_y[QB-1], q_y[QB-2:0]};
  assign out_seg_end  = div_tag.seg_end;
  assign out_path_end = div_tag.path_end;

  a_path_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_end |-> out_seg_end)
    else $error("path end without segment end");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n) j_r <= JW'(N1))
    else $error("sample index out of range");

endmodule

/* src/cubic_bezier_path_smoother_top.sv */
// The point that completes a segment reaches the output via the segment queue, stages s1
// to s4 and the divider. Throughput: one sample per cycle while a segment is queued and
// output is not stalled; NUM_SAMPLES beats per segment; the sequencer issues one t per cycle.
// Input is taken whenever the two-entry segment queue has room, also while output stalls.
// Reset: synchronous, active low; clears path state, queue and pipeline valids. No clear pass.
module cubic_bezier_path_smoother_top import cbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] point_x, [63:32] point_y
  input  logic        in_tlast,   // final_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] curve_x, [63:32] curve_y
  output logic        out_tlast,  // segment_end
  output logic [0:0]  out_tuser   // [0] path_end
);

  pt_t  in_pt;
  seg_t push_seg, head;
  logic push, full, pop, empty;
  logic [31:0] cx, cy;
  logic path_end;

  assign in_pt.x = in_tdata[31:0];
  assign in_pt.y = in_tdata[63:32];

  cbps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pt    (in_pt),
    .in_fin   (in_tlast),
    .q_full   (full),
    .push     (push),
    .push_seg (push_seg)
  );

  cbps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_seg (push_seg),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  cbps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (empty),
    .q_head       (head),
    .q_pop        (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_x        (cx),
    .out_y        (cy),
    .out_seg_end  (out_tlast),
    .out_path_end (path_end)
  );

  assign out_tdata = {cy, cx};
  assign out_tuser = path_end;

endmodule

/* dv/cubic_bezier_path_smoother_top_tb.sv */
// Self-checking testbench for cubic_bezier_path_smoother_top: streams waypoint paths,
// predicts every curve sample in SV and checks the sample beats in order.
// Depends on cbps_pkg (pt_t, NUM_SAMPLES) and the RTL under src.
module cubic_bezier_path_smoother_top_tb;
  import cbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HOLD_LEN   = 300;   // long receiver hold-off, in cycles
  localparam int          IDLE_LIMIT = 3000;  // cycles without any beat before giving up
  localparam int          SETTLE     = 60;    // exceeds the pipeline latency
  localparam logic [31:0] MAX_POS    = 32'h7fff_ffff;
  localparam logic [31:0] MIN_NEG    = 32'h8000_0000;
  localparam longint      SPAN       = NUM_SAMPLES - 1;
  localparam longint      SCALE      = SPAN * SPAN * SPAN;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic        seg_end;
    logic        path_end;
  } sample_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  // path state of the predictor
  pt_t prev_b;
  pt_t pair_a;
  pt_t pair_b;
  bit  odd_slot;
  bit  pair_held;
  bit  first_seg;

  sample_t curve_q[$];
  sample_t got_beat;
  int      err_count      = 0;
  int      idle_run       = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      hold_req       = 0;
  int      hold_ack       = 0;
  int      hold_left      = 0;

  cubic_bezier_path_smoother_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic pt_t mid_floor(pt_t a, pt_t b);
    longint sx;
    longint sy;
    pt_t    m;
    sx  = longint'($signed(a.x)) + longint'($signed(b.x));
    sy  = longint'($signed(a.y)) + longint'($signed(b.y));
    m.x = 32'(sx >>> 1);
    m.y = 32'(sy >>> 1);
    return m;
  endfunction

  function automatic void queue_segment(pt_t p0, pt_t p1, pt_t p2, pt_t p3, bit last);
    longint  a;
    longint  w0, w1, w2, w3;
    longint  sx, sy;
    sample_t s;
    for (longint j = 0; j < NUM_SAMPLES; j++) begin
      a  = SPAN - j;
      w0 = a * a * a;
      w1 = 3 * j * a * a;
      w2 = 3 * j * j * a;
      w3 = j * j * j;
      sx = w0 * longint'($signed(p0.x)) + w1 * longint'($signed(p1.x))
         + w2 * longint'($signed(p2.x)) + w3 * longint'($signed(p3.x));
      sy = w0 * longint'($signed(p0.y)) + w1 * longint'($signed(p1.y))
         + w2 * longint'($signed(p2.y)) + w3 * longint'($signed(p3.y));
      // round half up: floor((2S + D) / 2D)
      s.cx       = 32'(div_floor(2 * sx + SCALE, 2 * SCALE));
      s.cy       = 32'(div_floor(2 * sy + SCALE, 2 * SCALE));
      s.seg_end  = (j == SPAN);
      s.path_end = (j == SPAN) && last;
      curve_q.insert(curve_q.size(), s);
    end
  endfunction

  function automatic pt_t seg_start();
    return first_seg ? pair_a : mid_floor(prev_b, pair_a);
  endfunction

  function automatic void restart_path();
    odd_slot  = 1'b0;
    pair_held = 1'b0;
    first_seg = 1'b1;
  endfunction

  function automatic void predict_point(pt_t cur, bit fin);
    if (!odd_slot) begin
      if (pair_held) begin
        // segment waits for the next point to know its end midpoint
        queue_segment(seg_start(), pair_a, pair_b, fin ? pair_b : mid_floor(pair_b, cur), fin);
        prev_b    = pair_b;
        first_seg = 1'b0;
        pair_held = 1'b0;
      end
      if (fin) begin
        restart_path();   // trailing even-position point is dropped
      end else begin
        pair_a   = cur;
        odd_slot = 1'b1;
      end
    end else begin
      pair_b   = cur;
      odd_slot = 1'b0;
      if (fin) begin
        queue_segment(seg_start(), pair_a, pair_b, pair_b, 1'b1);
        prev_b = pair_b;
        restart_path();
      end else begin
        pair_held = 1'b1;
      end
    end
  endfunction

  function automatic void report_fail(string what, sample_t want, sample_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t ERROR %s: expected x=%h y=%h seg_end=%b path_end=%b,",
               $realtime, what, want.cx, want.cy, want.seg_end, want.path_end,
               " got x=%h y=%h seg_end=%b path_end=%b",
               got.cx, got.cy, got.seg_end, got.path_end);
  endfunction

  // ---------------------------------------------------------------- check and predict
  always @(posedge clk) begin : check_and_predict
    sample_t want;
    string   bad;
    pt_t     cur;
    if (!rst_n) begin
      prev_b = '0;
      pair_a = '0;
      pair_b = '0;
      restart_path();
    end else begin
      if (out_tvalid && out_tready) begin
        got_beat.cx       = out_tdata[31:0];
        got_beat.cy       = out_tdata[63:32];
        got_beat.seg_end  = out_tlast;
        got_beat.path_end = out_tuser[0];
        if (curve_q.size() == 0) begin
          want = '{default: '0};
          report_fail("sample beat with nothing expected", want, got_beat);
        end else begin
          want = curve_q.pop_front();
          bad  = "";
          if (got_beat.cx !== want.cx) bad = {bad, " curve_x"};
          if (got_beat.cy !== want.cy) bad = {bad, " curve_y"};
          if (got_beat.seg_end !== want.seg_end) bad = {bad, " segment_end"};
          if (got_beat.path_end !== want.path_end) bad = {bad, " path_end"};
          if (bad != "") report_fail({"mismatch on", bad}, want, got_beat);
        end
      end
      if (in_tvalid && in_tready) begin
        cur.x = in_tdata[31:0];
        cur.y = in_tdata[63:32];
        predict_point(cur, in_tlast);
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_ack   <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_run <= 0;
      end else if (idle_run >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_point(logic [31:0] px, logic [31:0] py, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return MAX_POS;
      1:       return MIN_NEG;
      2:       return '0;
      3, 4:    return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_path(int len);
    for (int i = 0; i < len; i++) send_point(rand_coord(), rand_coord(), i == len - 1);
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (curve_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    // lone point with the final mark: no segment
    send_point(32'h0001_8000, 32'hffff_0000, 1'b1);
    // two-point path at opposite corners
    send_point(MAX_POS, MIN_NEG, 1'b0);
    send_point(MIN_NEG, MAX_POS, 1'b1);
    // odd trailing point: pending pair ends at its own p2, third point dropped
    send_point(32'h0, 32'h0, 1'b0);
    send_point(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_point(MAX_POS, MIN_NEG, 1'b1);
    // several pairs with odd coordinate sums, midpoints round down
    send_point(32'hffff_fffd, 32'h0000_0003, 1'b0);
    send_point(32'h0000_0000, 32'hffff_ffff, 1'b0);
    send_point(32'h0000_0001, 32'h0000_0002, 1'b0);
    send_point(32'hffff_fffe, 32'h7fff_fffe, 1'b0);
    send_point(MAX_POS, MAX_POS, 1'b0);
    send_point(MIN_NEG, MIN_NEG, 1'b1);
    // all points at the most negative corner
    repeat (3) send_point(MIN_NEG, MIN_NEG, 1'b0);
    send_point(MIN_NEG, MIN_NEG, 1'b1);
    // all points at the most positive corner, odd count
    repeat (2) send_point(MAX_POS, MAX_POS, 1'b0);
    send_point(MAX_POS, MAX_POS, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int stall_pct);
    int sent;
    int len;
    send_idle_pct   = send_pct;
    recv_stall_pct <= stall_pct;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_path(len);
      sent += len;
    end
    wait_results_done();
  endtask

  task automatic test_backpressure();
    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    // receiver holds off while points keep coming: segment queue fills, input stalls
    hold_req <= hold_req + 1;
    send_path(24);
    // a short path follows; the sender then pauses until the output is drained and starts a new path
    send_path(5);
    wait_results_done();
    send_path(9);
    wait_results_done();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(110, 0, 0);
    test_random_traffic(100, 73, 0);
    test_random_traffic(100, 0, 73);
    test_random_traffic(100, 32, 32);
    test_backpressure();
    if (curve_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
